@@ hw/rtl/rrsdf_pkg.sv @@
`default_nettype none
package rrsdf_pkg;

   localparam int RED_SHIFT   = 16;
   localparam int GREEN_SHIFT = 8;
   localparam int BLUE_SHIFT  = 0;
   localparam int ALPHA_SHIFT = 24;
   localparam bit ALPHA_PRESENT = 1'b1;

   localparam int CSR_IDX_W = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_X      = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Y      = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_WIDTH    = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_HEIGHT   = 4'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CORNER_RADIUS = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BORDER_WIDTH  = 4'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_FILL_COLOR    = 4'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_SCALE     = 4'd7;

   localparam logic [15:0] INV_SCALE_RESET = 16'd4096;

   typedef struct packed {
      logic signed [23:0] center_x;
      logic signed [23:0] center_y;
      logic [22:0]        half_width;
      logic [22:0]        half_height;
      logic [22:0]        corner_radius;
      logic [22:0]        border_width;
      logic [31:0]        fill_color;
      logic [15:0]        inv_scale;
   } cfg_type;

   // front to back queue entry
   typedef struct packed {
      logic [52:0]        sum;
      logic signed [26:0] inner;
      logic [31:0]        dst;
   } qent_type;

endpackage
`default_nettype wire

@@ hw/rtl/rrsdf_if.sv @@
`default_nettype none
interface rrsdf_req_if;
   logic        valid;
   logic        ready;
   logic [11:0] pixel_x;
   logic [11:0] pixel_y;
   logic [31:0] dst_pixel;
   modport source (output valid, output pixel_x, output pixel_y, output dst_pixel,
                   input ready);
   modport sink (input valid, input pixel_x, input pixel_y, input dst_pixel,
                 output ready);
endinterface

interface rrsdf_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] pixel_out;
   logic        write_enable;
   modport source (output valid, output pixel_out, output write_enable, input ready);
   modport sink (input valid, input pixel_out, input write_enable, output ready);
endinterface

interface rrsdf_csr_if;
   logic        valid;
   logic        ready;
   logic [3:0]  index;
   logic [31:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/rounded_rect_sdf_blend.sv @@
// Pipeline: 4 front stages, a queue of 4 entries, 1 load plus 27 square-root digit
// stages, 9 coverage/blend stages; the square-root digit pipeline sets the depth.
// Throughput: one pixel per cycle while the response channel is not stalled.
// Reset (synchronous, active high) clears all pipeline valids and the queue and
// loads the register defaults: all zero, inv_scale 1.0 in Q4.12.
`default_nettype none
module rounded_rect_sdf_blend (
   input  wire logic   clock,
   input  wire logic   reset,
   rrsdf_req_if.sink   req_ch,
   rrsdf_rsp_if.source rsp_ch,
   rrsdf_csr_if.sink   csr_ch
);
   rrsdf_pkg::cfg_type  cfg;
   rrsdf_pkg::qent_type q_in, q_head;
   logic q_push, q_pop, q_full, q_empty;

   rrsdf_csr u_csr (.clock(clock), .reset(reset), .csr_ch(csr_ch), .cfg(cfg));

   rrsdf_front u_front (
      .clock(clock), .reset(reset), .cfg(cfg), .req_ch(req_ch),
      .q_full(q_full), .q_push(q_push), .q_data(q_in)
   );

   rrsdf_queue u_queue (
      .clock(clock), .reset(reset), .push(q_push), .push_data(q_in),
      .pop(q_pop), .full(q_full), .empty(q_empty), .head(q_head)
   );

   rrsdf_back u_back (
      .clock(clock), .reset(reset), .cfg(cfg), .q_empty(q_empty),
      .q_head(q_head), .q_pop(q_pop), .rsp_ch(rsp_ch)
   );
endmodule
`default_nettype wire

@@ hw/rtl/rrsdf_csr.sv @@
`default_nettype none
module rrsdf_csr (
   input  wire logic           clock,
   input  wire logic           reset,
   rrsdf_csr_if.sink           csr_ch,
   output rrsdf_pkg::cfg_type  cfg
);
   rrsdf_pkg::cfg_type cfg_ff;

   assign csr_ch.ready = 1'b1;
   assign cfg = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{inv_scale: rrsdf_pkg::INV_SCALE_RESET, default: '0};
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            rrsdf_pkg::CSR_CENTER_X:      cfg_ff.center_x <= $signed(csr_ch.data[23:0]);
            rrsdf_pkg::CSR_CENTER_Y:      cfg_ff.center_y <= $signed(csr_ch.data[23:0]);
            rrsdf_pkg::CSR_HALF_WIDTH:    cfg_ff.half_width <= csr_ch.data[22:0];
            rrsdf_pkg::CSR_HALF_HEIGHT:   cfg_ff.half_height <= csr_ch.data[22:0];
            rrsdf_pkg::CSR_CORNER_RADIUS: cfg_ff.corner_radius <= csr_ch.data[22:0];
            rrsdf_pkg::CSR_BORDER_WIDTH:  cfg_ff.border_width <= csr_ch.data[22:0];
            rrsdf_pkg::CSR_FILL_COLOR:    cfg_ff.fill_color <= csr_ch.data;
            rrsdf_pkg::CSR_INV_SCALE:     cfg_ff.inv_scale <= csr_ch.data[15:0];
            default: ;
         endcase
      end
   end
endmodule
`default_nettype wire

@@ hw/rtl/rrsdf_front.sv @@
`default_nettype none
module rrsdf_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  rrsdf_pkg::cfg_type       cfg,
   rrsdf_req_if.sink                req_ch,
   input  wire logic                q_full,
   output logic                     q_push,
   output rrsdf_pkg::qent_type      q_data
);
   logic front_en;
   logic f1_v_ff, f2_v_ff, f3_v_ff, f4_v_ff;
   logic [23:0] lx_ff, ly_ff, lx_in, ly_in;
   logic [31:0] f1_dst_ff, f2_dst_ff, f3_dst_ff, f4_dst_ff;
   logic signed [25:0] dx_ff, dy_ff, dx_in, dy_in;
   logic signed [26:0] qx_ff, qy_ff, qx_in, qy_in;
   logic [51:0] sqx_ff, sqy_ff, sqx_in, sqy_in;
   logic signed [26:0] inner_ff, inner_in;

   assign front_en = !f4_v_ff || !q_full;
   assign req_ch.ready = front_en;
   assign q_push = f4_v_ff && !q_full;
   assign q_data.sum = 53'(sqx_ff) + 53'(sqy_ff);
   assign q_data.inner = inner_ff;
   assign q_data.dst = f4_dst_ff;

   always_comb begin
      logic [28:0] px, py;
      logic signed [25:0] ax, ay;
      logic signed [26:0] hw, hh, cr, mq;
      logic [25:0] mx, my;
      px = 29'({req_ch.pixel_x, 1'b1}) * 29'(cfg.inv_scale) + 29'd16;
      py = 29'({req_ch.pixel_y, 1'b1}) * 29'(cfg.inv_scale) + 29'd16;
      lx_in = px[28:5];
      ly_in = py[28:5];
      dx_in = $signed({2'b00, lx_ff}) - 26'(cfg.center_x);
      dy_in = $signed({2'b00, ly_ff}) - 26'(cfg.center_y);
      ax = dx_ff[25] ? -dx_ff : dx_ff;
      ay = dy_ff[25] ? -dy_ff : dy_ff;
      hw = $signed({4'b0000, cfg.half_width});
      hh = $signed({4'b0000, cfg.half_height});
      cr = $signed({4'b0000, cfg.corner_radius});
      qx_in = 27'(ax) - hw + cr;
      qy_in = 27'(ay) - hh + cr;
      mx = (qx_ff > 0) ? qx_ff[25:0] : 26'd0;
      my = (qy_ff > 0) ? qy_ff[25:0] : 26'd0;
      sqx_in = 52'(mx) * 52'(mx);
      sqy_in = 52'(my) * 52'(my);
      mq = (qx_ff > qy_ff) ? qx_ff : qy_ff;
      inner_in = (mq > 0) ? 27'sd0 : mq;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_v_ff <= 1'b0;
         f2_v_ff <= 1'b0;
         f3_v_ff <= 1'b0;
         f4_v_ff <= 1'b0;
      end else if (front_en) begin
         f1_v_ff <= req_ch.valid;
         f2_v_ff <= f1_v_ff;
         f3_v_ff <= f2_v_ff;
         f4_v_ff <= f3_v_ff;
      end
      if (front_en) begin
         lx_ff <= lx_in;
         ly_ff <= ly_in;
         f1_dst_ff <= req_ch.dst_pixel;
         dx_ff <= dx_in;
         dy_ff <= dy_in;
         f2_dst_ff <= f1_dst_ff;
         qx_ff <= qx_in;
         qy_ff <= qy_in;
         f3_dst_ff <= f2_dst_ff;
         sqx_ff <= sqx_in;
         sqy_ff <= sqy_in;
         inner_ff <= inner_in;
         f4_dst_ff <= f3_dst_ff;
      end
   end
endmodule
`default_nettype wire

@@ hw/rtl/rrsdf_queue.sv @@
`default_nettype none
module rrsdf_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  rrsdf_pkg::qent_type     push_data,
   input  wire logic               pop,
   output logic                    full,
   output logic                    empty,
   output rrsdf_pkg::qent_type     head
);
   rrsdf_pkg::qent_type mem_ff [4];
   logic [1:0] wr_ptr_ff, rd_ptr_ff;
   logic [2:0] count_ff;

   assign full = (count_ff == 3'd4);
   assign empty = (count_ff == 3'd0);
   assign head = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 2'd1;
         if (pop) rd_ptr_ff <= rd_ptr_ff + 2'd1;
         count_ff <= count_ff + 3'(push) - 3'(pop);
      end
      if (push) mem_ff[wr_ptr_ff] <= push_data;
   end
endmodule
`default_nettype wire

@@ hw/rtl/rrsdf_back.sv @@
`default_nettype none
module rrsdf_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  rrsdf_pkg::cfg_type      cfg,
   input  wire logic               q_empty,
   input  rrsdf_pkg::qent_type     q_head,
   output logic                    q_pop,
   rrsdf_rsp_if.source             rsp_ch
);
   localparam int NSQ = 27;

   logic bk_en;
   // square root pipeline, one digit per stage
   logic               sq_v_ff   [NSQ+1];
   logic [52:0]        sq_n_ff   [NSQ+1];
   logic [52:0]        sq_r_ff   [NSQ+1];
   logic signed [26:0] sq_in_ff  [NSQ+1];
   logic [31:0]        sq_dst_ff [NSQ+1];
   logic [52:0]        sq_n_in   [NSQ];
   logic [52:0]        sq_r_in   [NSQ];

   logic rd_v_ff, c1_v_ff, c2_v_ff, c3_v_ff, c4_v_ff, c5_v_ff, c6_v_ff, c7_v_ff, out_v_ff;
   logic [31:0] rd_dst_ff, c1_dst_ff, c2_dst_ff, c3_dst_ff, c4_dst_ff, c5_dst_ff;
   logic [31:0] c6_dst_ff, c7_dst_ff;
   logic signed [29:0] d0_ff, d1_ff, d0_in, d1_in;
   logic [1:0]  le0_ff, ge_ff;
   logic [15:0] dd_ff [2];
   logic [8:0]  t_ff  [2];
   logic [16:0] cov_ff [2];
   logic [16:0] cov_in [2];
   logic [16:0] c_ff, c_in;
   logic [24:0] x_ff, x5_ff;
   logic [17:0] q0_ff;
   logic [16:0] a_ff, a_in;
   logic [24:0] sp_ff [3];
   logic [24:0] dp_ff [3];
   logic        azero_ff;
   logic [31:0] out_word_ff, out_word_in;
   logic        out_we_ff;

   assign bk_en = !out_v_ff || rsp_ch.ready;
   assign q_pop = bk_en && !q_empty;
   assign rsp_ch.valid = out_v_ff;
   assign rsp_ch.pixel_out = out_word_ff;
   assign rsp_ch.write_enable = out_we_ff;

   always_comb begin
      logic [52:0] bitv;
      logic [52:0] trial;
      for (int k = 0; k < NSQ; k++) begin
         bitv = 53'd1 << (52 - 2 * k);
         trial = sq_r_ff[k] + bitv;
         if (sq_n_ff[k] >= trial) begin
            sq_n_in[k] = sq_n_ff[k] - trial;
            sq_r_in[k] = (sq_r_ff[k] >> 1) + bitv;
         end else begin
            sq_n_in[k] = sq_n_ff[k];
            sq_r_in[k] = sq_r_ff[k] >> 1;
         end
      end
   end

   always_comb begin
      logic [52:0] rt;
      logic signed [29:0] base;
      logic [24:0] p;
      logic signed [17:0] diff;
      logic [24:0] rem;
      logic [24:0] sum;
      logic [7:0] mch [3];
      logic [31:0] opaque;
      logic [16:0] t0, t1;
      rt = sq_r_ff[NSQ] + 53'(sq_n_ff[NSQ] > sq_r_ff[NSQ]);
      base = 30'(sq_in_ff[NSQ]) + $signed({2'b00, rt[27:0]})
             - $signed({7'd0, cfg.corner_radius});
      d0_in = base;
      d1_in = base + $signed({7'd0, cfg.border_width});
      for (int i = 0; i < 2; i++) begin
         p = 25'(dd_ff[i]) * 25'(t_ff[i]) + 25'd64;
         if (le0_ff[i]) cov_in[i] = 17'd65536;
         else if (ge_ff[i]) cov_in[i] = 17'd0;
         else cov_in[i] = 17'd65536 - 17'(p[24:7]);
      end
      diff = $signed({1'b0, cov_ff[0]}) - $signed({1'b0, cov_ff[1]});
      if (cfg.border_width == 23'd0) c_in = cov_ff[0];
      else if (diff < 0) c_in = 17'd0;
      else c_in = diff[16:0];
      // x / 255 from a low reciprocal, then at most three steps up
      rem = x5_ff - 25'({q0_ff, 8'd0}) + 25'(q0_ff);
      t0 = 17'(q0_ff) + 17'(rem >= 25'd255) + 17'(rem >= 25'd510);
      t1 = 17'(rem >= 25'd765);
      a_in = t0 + t1;
      for (int i = 0; i < 3; i++) begin
         sum = sp_ff[i] + dp_ff[i] + 25'd32768;
         mch[i] = sum[23:16];
      end
      opaque = rrsdf_pkg::ALPHA_PRESENT ? (32'h0000_00FF << rrsdf_pkg::ALPHA_SHIFT) : 32'd0;
      if (azero_ff) out_word_in = c7_dst_ff;
      else out_word_in = (32'(mch[0]) << rrsdf_pkg::RED_SHIFT)
                         | (32'(mch[1]) << rrsdf_pkg::GREEN_SHIFT)
                         | (32'(mch[2]) << rrsdf_pkg::BLUE_SHIFT) | opaque;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= NSQ; k++) sq_v_ff[k] <= 1'b0;
         rd_v_ff <= 1'b0;
         c1_v_ff <= 1'b0;
         c2_v_ff <= 1'b0;
         c3_v_ff <= 1'b0;
         c4_v_ff <= 1'b0;
         c5_v_ff <= 1'b0;
         c6_v_ff <= 1'b0;
         c7_v_ff <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (bk_en) begin
         sq_v_ff[0] <= !q_empty;
         for (int k = 0; k < NSQ; k++) sq_v_ff[k+1] <= sq_v_ff[k];
         rd_v_ff <= sq_v_ff[NSQ];
         c1_v_ff <= rd_v_ff;
         c2_v_ff <= c1_v_ff;
         c3_v_ff <= c2_v_ff;
         c4_v_ff <= c3_v_ff;
         c5_v_ff <= c4_v_ff;
         c6_v_ff <= c5_v_ff;
         c7_v_ff <= c6_v_ff;
         out_v_ff <= c7_v_ff;
      end
      if (bk_en) begin
         sq_n_ff[0] <= q_head.sum;
         sq_r_ff[0] <= '0;
         sq_in_ff[0] <= q_head.inner;
         sq_dst_ff[0] <= q_head.dst;
         for (int k = 0; k < NSQ; k++) begin
            sq_n_ff[k+1] <= sq_n_in[k];
            sq_r_ff[k+1] <= sq_r_in[k];
            sq_in_ff[k+1] <= sq_in_ff[k];
            sq_dst_ff[k+1] <= sq_dst_ff[k];
         end
         d0_ff <= d0_in;
         d1_ff <= d1_in;
         rd_dst_ff <= sq_dst_ff[NSQ];
         le0_ff[0] <= (d0_ff <= 0);
         le0_ff[1] <= (d1_ff <= 0);
         ge_ff[0] <= (d0_ff >= 256);
         ge_ff[1] <= (d1_ff >= 256);
         dd_ff[0] <= 16'(d0_ff[7:0]) * 16'(d0_ff[7:0]);
         dd_ff[1] <= 16'(d1_ff[7:0]) * 16'(d1_ff[7:0]);
         t_ff[0] <= 9'd384 - 9'(d0_ff[7:0]);
         t_ff[1] <= 9'd384 - 9'(d1_ff[7:0]);
         c1_dst_ff <= rd_dst_ff;
         cov_ff[0] <= cov_in[0];
         cov_ff[1] <= cov_in[1];
         c2_dst_ff <= c1_dst_ff;
         c_ff <= c_in;
         c3_dst_ff <= c2_dst_ff;
         x_ff <= 25'(cfg.fill_color[7:0]) * 25'(c_ff) + 25'd127;
         c4_dst_ff <= c3_dst_ff;
         x5_ff <= x_ff;
         q0_ff <= 18'((41'(x_ff) * 41'd32896) >> 23);
         c5_dst_ff <= c4_dst_ff;
         a_ff <= a_in;
         c6_dst_ff <= c5_dst_ff;
         sp_ff[0] <= 25'(cfg.fill_color[31:24]) * 25'(a_ff);
         sp_ff[1] <= 25'(cfg.fill_color[23:16]) * 25'(a_ff);
         sp_ff[2] <= 25'(cfg.fill_color[15:8]) * 25'(a_ff);
         dp_ff[0] <= 25'((c6_dst_ff >> rrsdf_pkg::RED_SHIFT) & 32'hFF)
                     * 25'(17'd65536 - a_ff);
         dp_ff[1] <= 25'((c6_dst_ff >> rrsdf_pkg::GREEN_SHIFT) & 32'hFF)
                     * 25'(17'd65536 - a_ff);
         dp_ff[2] <= 25'((c6_dst_ff >> rrsdf_pkg::BLUE_SHIFT) & 32'hFF)
                     * 25'(17'd65536 - a_ff);
         azero_ff <= (a_ff == 17'd0);
         c7_dst_ff <= c6_dst_ff;
         out_word_ff <= out_word_in;
         out_we_ff <= !azero_ff;
      end
   end
endmodule
`default_nettype wire

@@ hw/rtl/rrsdf_checker.sv @@
`default_nettype none
module rrsdf_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] pixel_out,
   input wire logic        write_enable
);
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_opaque: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && write_enable |-> pixel_out[31:24] == 8'hFF)
      else $error("written pixel not opaque");
endmodule

bind rounded_rect_sdf_blend rrsdf_checker u_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready),
   .pixel_out(rsp_ch.pixel_out), .write_enable(rsp_ch.write_enable)
);
`default_nettype wire
